@@ src/abd_pkg.sv @@
// shared types and constants for the audio beat detector
`timescale 1ns / 1ps
`default_nettype none
package abd_pkg;

   localparam int DataWidth    = 32;
   localparam int CoefWidth    = 32;
   localparam int DecWidth     = 16;
   localparam int GainWidth    = 10;
   localparam int HistoryDepthDefault = 9;

   localparam logic signed [CoefWidth-1:0] C_BASS_IN = 32'sd117993607;
   localparam logic signed [CoefWidth-1:0] C_BASS_Y2 = -32'sd854704936;
   localparam logic signed [CoefWidth-1:0] C_BASS_Y1 = 32'sd1922333318;
   localparam logic signed [CoefWidth-1:0] C_ENV_IN  = 32'sd6710886;
   localparam logic signed [CoefWidth-1:0] C_ENV_Y1  = 32'sd1060332861;
   localparam logic signed [CoefWidth-1:0] C_SM_PREV = 32'sd1063004406;
   localparam logic signed [CoefWidth-1:0] C_SM_NEW  = 32'sd10737418;
   localparam logic signed [CoefWidth-1:0] C_BEAT_IN = 32'sd153063696;
   localparam logic signed [CoefWidth-1:0] C_BEAT_Y2 = -32'sd769858042;
   localparam logic signed [CoefWidth-1:0] C_BEAT_Y1 = 32'sd1551949227;

   localparam logic [DecWidth-1:0]  DecimationReset = 16'd62;
   localparam logic [GainWidth-1:0] GainReset       = 10'd145;
   localparam logic [GainWidth-1:0] OffsetReset     = 10'd45;

   localparam logic [1:0] RegDecimation = 2'd0;
   localparam logic [1:0] RegGain       = 2'd1;
   localparam logic [1:0] RegOffset     = 2'd2;

   // datapath operations, one per controller step
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,       // scale sample into x
      OP_MUL_BIN,    // acc = round(c*x)
      OP_SAT_XS,     // xs = sat(acc), acc = xs - bass_in_hist0
      OP_MUL_BY2,    // acc += round(c*y2)
      OP_MUL_BY1,    // acc += round(c*y1)
      OP_BASS_DONE,  // y = sat, shift history, mag
      OP_MUL_EIN,    // acc = round(c*mag)
      OP_SAT_XE,     // xe = sat(acc), acc = env_in_prev + xe
      OP_MUL_EY1,
      OP_ENV_DONE,   // ye = sat, x = ye
      OP_MUL_SMP,
      OP_MUL_SMN,
      OP_SM_DONE,
      OP_MUL_TIN,
      OP_SAT_BX,
      OP_MUL_TY2,
      OP_MUL_TY1,
      OP_BEAT_DONE,  // by = sat, start history sum
      OP_SUM,        // add one history entry
      OP_DIV,        // one 16-bit chunk of the reciprocal multiply
      OP_JUDGE_MUL,
      OP_JUDGE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   clear;    // reset sum / divider step count
   } dp_cmd_type;

   typedef struct packed {
      logic sum_last;
      logic div_last;
   } dp_status_type;

   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[DataWidth-1:0];
   endfunction

endpackage
`default_nettype wire

@@ src/abd_datapath.sv @@
// datapath: one shared filter multiplier, accumulator, filter state and beat history
`timescale 1ns / 1ps
`default_nettype none
module abd_datapath import abd_pkg::*; #(
   parameter int HistoryDepth = HistoryDepthDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dp_cmd_type                  cmd,
   output dp_status_type                    status,
   input  wire logic signed [15:0]          sample,
   input  wire logic [GainWidth-1:0]        gain,
   input  wire logic [GainWidth-1:0]        offset,
   output logic signed [DataWidth-1:0]      env_out,
   output logic signed [DataWidth-1:0]      beat_out,
   output logic                             found_out
);
   localparam int IdxW = $clog2(HistoryDepth);
   localparam int SumW = DataWidth + IdxW + 1;
   // average by reciprocal multiply, exact for magnitudes below 2^MagW
   localparam int MagW       = DataWidth + IdxW;
   localparam int RecipShift = MagW + IdxW;
   localparam int RecipW     = MagW + 2;
   localparam longint RecipFull = ((64'sd1 <<< RecipShift) + longint'(HistoryDepth) - 1)
                                  / longint'(HistoryDepth);
   localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);
   localparam int ChunkW    = 16;
   localparam int NumChunks = (SumW + ChunkW - 1) / ChunkW;
   localparam int PadW      = NumChunks * ChunkW;
   localparam int ProdW     = PadW + RecipW;

   logic signed [DataWidth-1:0] bih0_ff, bih1_ff, boh0_ff, boh1_ff;
   logic signed [DataWidth-1:0] eip_ff, eop_ff, sm_ff;
   logic signed [DataWidth-1:0] tih0_ff, tih1_ff, toh0_ff, toh1_ff;
   logic signed [DataWidth-1:0] hist_ff [HistoryDepth];
   logic signed [DataWidth-1:0] x_ff, beat_ff;
   logic signed [65:0]          acc_ff;
   logic [IdxW-1:0]             idx_ff;
   logic [5:0]                  step_ff;
   logic signed [SumW-1:0]      sum_ff;
   logic [PadW-1:0]             mag_sh_ff;
   logic [ProdW-1:0]            prod_ff;
   logic                        neg_ff, found_ff;
   logic signed [DataWidth-1:0] by_ff;

   logic signed [CoefWidth-1:0] coef;
   logic signed [DataWidth-1:0] opnd;
   logic signed [63:0]          prod;
   logic signed [65:0]          rnd;
   logic signed [DataWidth-1:0] acc_sat;
   logic [SumW-1:0]             sum_mag, quo;
   logic [ProdW-1:0]            part;
   logic signed [SumW:0]        avg;
   logic signed [SumW+GainWidth+1:0] lhs, rhs;

   always_comb begin
      coef = C_BASS_IN;
      opnd = x_ff;
      unique case (cmd.op)
         OP_MUL_BIN: begin coef = C_BASS_IN; opnd = x_ff; end
         OP_MUL_BY2: begin coef = C_BASS_Y2; opnd = boh0_ff; end
         OP_MUL_BY1: begin coef = C_BASS_Y1; opnd = boh1_ff; end
         OP_MUL_EIN: begin coef = C_ENV_IN;  opnd = x_ff; end
         OP_MUL_EY1: begin coef = C_ENV_Y1;  opnd = eop_ff; end
         OP_MUL_SMP: begin coef = C_SM_PREV; opnd = sm_ff; end
         OP_MUL_SMN: begin coef = C_SM_NEW;  opnd = x_ff; end
         OP_MUL_TIN: begin coef = C_BEAT_IN; opnd = sm_ff; end
         OP_MUL_TY2: begin coef = C_BEAT_Y2; opnd = toh0_ff; end
         OP_MUL_TY1: begin coef = C_BEAT_Y1; opnd = toh1_ff; end
         default: ;
      endcase
   end

   // round to nearest, ties up: add half then floor shift
   assign prod    = coef * opnd;
   assign rnd     = (66'(prod) + 66'sd536870912) >>> 30;
   assign acc_sat = sat32(acc_ff);
   assign sum_mag = sum_ff[SumW-1] ? SumW'(-sum_ff) : SumW'(sum_ff);
   // one 16-bit chunk of the magnitude times the reciprocal, top chunk first
   assign part    = ProdW'(mag_sh_ff[PadW-1 -: ChunkW]) * ProdW'(Recip);
   assign quo     = SumW'(prod_ff >> RecipShift);
   assign avg     = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   assign lhs     = (SumW+GainWidth+2)'(avg) * $signed({1'b0, gain});
   assign rhs     = (SumW+GainWidth+2)'(by_ff)
                    - (SumW+GainWidth+2)'($signed({1'b0, offset, 16'd0}));

   always_ff @(posedge clock) begin
      if (reset) begin
         bih0_ff <= '0; bih1_ff <= '0; boh0_ff <= '0; boh1_ff <= '0;
         eip_ff <= '0; eop_ff <= '0; sm_ff <= '0;
         tih0_ff <= '0; tih1_ff <= '0; toh0_ff <= '0; toh1_ff <= '0;
         beat_ff <= '0; found_ff <= 1'b0;
         for (int i = 0; i < HistoryDepth; i++) hist_ff[i] <= '0;
      end else begin
         unique case (cmd.op)
            OP_LOAD: begin
               x_ff <= DataWidth'(sample) <<< 14;
               found_ff <= 1'b0;
            end
            OP_MUL_BIN, OP_MUL_EIN, OP_MUL_TIN: acc_ff <= rnd;
            OP_MUL_BY2, OP_MUL_BY1, OP_MUL_EY1, OP_MUL_SMN, OP_MUL_TY2, OP_MUL_TY1:
               acc_ff <= acc_ff + rnd;
            OP_MUL_SMP: acc_ff <= rnd;
            OP_SAT_XS: begin
               bih0_ff <= bih1_ff; bih1_ff <= acc_sat;
               acc_ff <= 66'(acc_sat) - 66'(bih0_ff);
            end
            OP_BASS_DONE: begin
               boh0_ff <= boh1_ff; boh1_ff <= acc_sat;
               x_ff <= (acc_sat == 32'sh80000000) ? 32'sh7fffffff :
                       (acc_sat < 0) ? -acc_sat : acc_sat;
            end
            OP_SAT_XE: begin
               eip_ff <= acc_sat;
               acc_ff <= 66'(acc_sat) + 66'(eip_ff);
            end
            OP_ENV_DONE: begin
               eop_ff <= acc_sat;
               x_ff <= acc_sat;
            end
            OP_SM_DONE: sm_ff <= acc_sat;
            OP_SAT_BX: begin
               tih0_ff <= tih1_ff; tih1_ff <= acc_sat;
               acc_ff <= 66'(acc_sat) - 66'(tih0_ff);
            end
            OP_BEAT_DONE: begin
               toh0_ff <= toh1_ff; toh1_ff <= acc_sat;
               by_ff <= acc_sat; beat_ff <= acc_sat;
            end
            OP_SUM: begin
               if (cmd.clear) sum_ff <= SumW'(hist_ff[0]);
               else sum_ff <= sum_ff + SumW'(hist_ff[idx_ff]);
            end
            OP_DIV: begin
               if (cmd.clear) begin
                  neg_ff <= sum_ff[SumW-1];
                  mag_sh_ff <= PadW'(sum_mag);
                  prod_ff <= '0;
               end else begin
                  prod_ff <= (prod_ff << ChunkW) + part;
                  mag_sh_ff <= mag_sh_ff << ChunkW;
               end
            end
            OP_JUDGE: begin
               found_ff <= lhs < rhs;
               for (int i = 0; i + 1 < HistoryDepth; i++) hist_ff[i] <= hist_ff[i+1];
               hist_ff[HistoryDepth-1] <= by_ff;
            end
            default: ;
         endcase
      end
   end

   // history index and divider step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0; step_ff <= '0;
      end else if (cmd.op == OP_SUM) begin
         idx_ff <= cmd.clear ? IdxW'(1) : idx_ff + IdxW'(1);
      end else if (cmd.op == OP_DIV) begin
         step_ff <= cmd.clear ? '0 : step_ff + 6'd1;
      end
   end

   assign status.sum_last = (cmd.op == OP_SUM) && !cmd.clear
                            && (idx_ff == IdxW'(HistoryDepth - 1));
   assign status.div_last = (cmd.op == OP_DIV) && !cmd.clear
                            && (step_ff == 6'(NumChunks - 1));
   assign env_out   = sm_ff;
   assign beat_out  = beat_ff;
   assign found_out = found_ff;
endmodule
`default_nettype wire

@@ src/abd_controller.sv @@
// controller: steps the shared datapath through one sample
`timescale 1ns / 1ps
`default_nettype none
module abd_controller import abd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   input  wire logic [DecWidth-1:0]  decimation,
   output dp_cmd_type                cmd,
   input  wire dp_status_type        status,
   output logic                      upd_out
);
   typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_type;

   state_type          state_ff;
   op_type             op_ff;
   logic               clear_ff, upd_ff, out_valid_ff;
   logic [DecWidth-1:0] cnt_ff, cnt_inc, limit;

   assign limit   = (decimation == '0) ? DecWidth'(1) : decimation;
   assign cnt_inc = cnt_ff + DecWidth'(1);
   assign in_ready = (state_ff == S_IDLE) || (state_ff == S_OUT && out_ready);
   // the sample is loaded at the edge that accepts it
   assign cmd.op    = (state_ff == S_RUN) ? op_ff :
                      ((in_valid && in_ready) ? OP_LOAD : OP_NONE);
   assign cmd.clear = clear_ff;
   assign out_valid = out_valid_ff;
   assign upd_out   = upd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; op_ff <= OP_NONE; clear_ff <= 1'b0;
         upd_ff <= 1'b0; out_valid_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         clear_ff <= 1'b0;
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE, S_OUT: begin
               if (state_ff == S_OUT && out_ready) state_ff <= S_IDLE;
               if (in_valid && in_ready) begin
                  state_ff <= S_RUN; op_ff <= OP_MUL_BIN;
               end
            end
            S_RUN: begin
               unique case (op_ff)
                  OP_MUL_BIN:  op_ff <= OP_SAT_XS;
                  OP_SAT_XS:   op_ff <= OP_MUL_BY2;
                  OP_MUL_BY2:  op_ff <= OP_MUL_BY1;
                  OP_MUL_BY1:  op_ff <= OP_BASS_DONE;
                  OP_BASS_DONE: op_ff <= OP_MUL_EIN;
                  OP_MUL_EIN:  op_ff <= OP_SAT_XE;
                  OP_SAT_XE:   op_ff <= OP_MUL_EY1;
                  OP_MUL_EY1:  op_ff <= OP_ENV_DONE;
                  OP_ENV_DONE: op_ff <= OP_MUL_SMP;
                  OP_MUL_SMP:  op_ff <= OP_MUL_SMN;
                  OP_MUL_SMN:  op_ff <= OP_SM_DONE;
                  OP_SM_DONE: begin
                     if (cnt_inc >= limit) begin
                        cnt_ff <= '0; upd_ff <= 1'b1; op_ff <= OP_MUL_TIN;
                     end else begin
                        cnt_ff <= cnt_inc; upd_ff <= 1'b0;
                        state_ff <= S_OUT; out_valid_ff <= 1'b1; op_ff <= OP_NONE;
                     end
                  end
                  OP_MUL_TIN:  op_ff <= OP_SAT_BX;
                  OP_SAT_BX:   op_ff <= OP_MUL_TY2;
                  OP_MUL_TY2:  op_ff <= OP_MUL_TY1;
                  OP_MUL_TY1:  op_ff <= OP_BEAT_DONE;
                  OP_BEAT_DONE: begin op_ff <= OP_SUM; clear_ff <= 1'b1; end
                  OP_SUM: if (status.sum_last) begin
                     op_ff <= OP_DIV; clear_ff <= 1'b1;
                  end
                  OP_DIV: if (status.div_last) op_ff <= OP_JUDGE;
                  OP_JUDGE: begin
                     state_ff <= S_OUT; out_valid_ff <= 1'b1; op_ff <= OP_NONE;
                  end
                  default: op_ff <= OP_NONE;
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ src/audio_beat_detector.sv @@
// top level of the audio beat detector
// usage:
//   req_ channel carries one signed 16-bit pcm sample per transaction
//   rsp_ channel returns one transaction per sample: envelope, last beat
//     level, an update flag and a beat flag
//   csr_ is an apb-style port: 0x0 decimation count, 0x4 judge gain,
//     0x8 judge offset; writes only while the block is idle
// timing:
//   the sample is loaded at its accepting edge; the result is valid once
//   the bass filter, envelope and smoothing steps are done; a sample that
//   runs the beat filter adds 5 filter steps, HistoryDepth history adds,
//   4 steps of reciprocal multiply for the average and the compare
//   one shared 32x32 multiplier runs every filter product in turn
//   one sample is in flight at a time; a new sample is taken in the same
//   cycle that the previous result is taken
// reset:
//   synchronous, clears all filter state, history and the sample counter,
//   and loads the register defaults
// stall:
//   the result holds on rsp_ until taken; req_ready stays low meanwhile
`timescale 1ns / 1ps
`default_nettype none
module audio_beat_detector import abd_pkg::*; #(
   parameter int HistoryDepth = HistoryDepthDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [15:0]       req_pcm_sample,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DataWidth-1:0]   rsp_envelope_level,
   output logic signed [DataWidth-1:0]   rsp_beat_level,
   output logic                          rsp_update_done,
   output logic                          rsp_beat_found,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [3:0]               paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   logic [DecWidth-1:0]  dec_ff;
   logic [GainWidth-1:0] gain_ff, offset_ff;
   logic [1:0]           reg_idx;
   logic                 wr_en;
   dp_cmd_type           cmd;
   dp_status_type        status;

   // register file, word addressed
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= DecimationReset; gain_ff <= GainReset; offset_ff <= OffsetReset;
      end else if (wr_en) begin
         priority case (reg_idx)
            RegDecimation: dec_ff    <= pwdata[DecWidth-1:0];
            RegGain:       gain_ff   <= pwdata[GainWidth-1:0];
            RegOffset:     offset_ff <= pwdata[GainWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority case (reg_idx)
         RegDecimation: prdata = 32'(dec_ff);
         RegGain:       prdata = 32'(gain_ff);
         RegOffset:     prdata = 32'(offset_ff);
         default:       prdata = '0;
      endcase
   end

   abd_controller u_ctrl (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .decimation(dec_ff), .cmd, .status, .upd_out(rsp_update_done)
   );

   abd_datapath #(.HistoryDepth(HistoryDepth)) u_dp (
      .clock, .reset, .cmd, .status,
      .sample(req_pcm_sample), .gain(gain_ff), .offset(offset_ff),
      .env_out(rsp_envelope_level), .beat_out(rsp_beat_level),
      .found_out(rsp_beat_found)
   );

   // a beat can only be flagged on a beat filter update
   a_found_needs_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat_found |-> rsp_update_done)
      else $error("beat flagged without update");

   // no new sample while a result waits
   a_no_accept_while_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   // result stays stable while stalled
   a_env_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_envelope_level))
      else $error("envelope changed while stalled");
endmodule
`default_nettype wire
